// ----- design/mst_pkg.sv -----
package mst_pkg;

    // fixed field widths
    localparam int VAL_W        = 32;
    localparam int REQ_W        = 2;
    localparam int STAT_W       = 3;
    localparam int MCNT_W       = 7;
    localparam int CAPACITY_DEF = 64;

    // request codes
    localparam logic [REQ_W-1:0] OP_FIND   = 2'd0;
    localparam logic [REQ_W-1:0] OP_ADD    = 2'd1;
    localparam logic [REQ_W-1:0] OP_REMOVE = 2'd2;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_FOUND     = 3'd0,
        STAT_NOT_FOUND = 3'd1,
        STAT_ADDED     = 3'd2,
        STAT_REMOVED   = 3'd3,
        STAT_FULL      = 3'd4,
        STAT_EMPTY     = 3'd5
    } status_t;

    // what a token does as it passes each cell
    typedef enum logic [1:0] {
        TK_SEARCH = 2'd0,
        TK_INSERT = 2'd1,
        TK_DELETE = 2'd2
    } tok_kind_t;

    // token handed from cell to cell
    typedef struct packed {
        logic             act;
        tok_kind_t        kind;
        logic [VAL_W-1:0] value;
        logic             flag;
    } tok_t;

    // controller phases
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_SEARCH = 2'd1,
        PH_INSERT = 2'd2
    } phase_t;

endpackage

// ----- design/membership_set_table.sv -----
// set of distinct 32-bit values held in a chain of CAPACITY cells, one entry per cell
// a transaction is a token that walks the chain one cell per cycle
// find, remove and failed add make one pass down the chain from start to done;
// a successful add makes a search pass, then an insert pass
// one transaction at a time; a new start is taken in the cycle done is shown
// rst_n clears all entries, the count and the controller; the receiver cannot stall
module membership_set_table #(
    parameter int CAPACITY = mst_pkg::CAPACITY_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [mst_pkg::REQ_W-1:0]        req_type,
    input  logic signed [mst_pkg::VAL_W-1:0] item_value,
    output logic                             done,
    output logic [mst_pkg::STAT_W-1:0]       status,
    output logic [mst_pkg::MCNT_W-1:0]       member_count
);
    import mst_pkg::*;

    tok_t chain [0:CAPACITY];

    // controller launches tokens and collects them at the tail
    mst_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .req_type     (req_type),
        .item_value   (item_value),
        .tail         (chain[CAPACITY]),
        .launch       (chain[0]),
        .busy         (busy),
        .done         (done),
        .status       (status),
        .member_count (member_count)
    );

    // row of entry cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        mst_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

endmodule

// ----- design/mst_cell.sv -----
module mst_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  mst_pkg::tok_t tok_in,
    output mst_pkg::tok_t tok_out
);
    import mst_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    logic [VAL_W-1:0] value_reg;
    logic [VAL_W-1:0] value_next;
    tok_t             tok_reg;
    tok_t             tok_next;
    logic             match;

    // compare against the held entry
    assign match = valid_reg && (value_reg == tok_in.value);

    // per-cell action on the passing token
    always_comb
    begin
        tok_next   = tok_in;
        valid_next = valid_reg;
        value_next = value_reg;
        if (tok_in.act)
        begin
            unique case (tok_in.kind)
                TK_SEARCH:
                begin
                    tok_next.flag = tok_in.flag | match;
                end
                TK_DELETE:
                begin
                    if (match)
                    begin
                        valid_next    = 1'b0;
                        tok_next.flag = 1'b1;
                    end
                end
                TK_INSERT:
                begin
                    // first free cell along the chain claims the value
                    if (!valid_reg && !tok_in.flag)
                    begin
                        valid_next    = 1'b1;
                        value_next    = tok_in.value;
                        tok_next.flag = 1'b1;
                    end
                end
                default:
                begin
                    tok_next = tok_in;
                end
            endcase
        end
    end

    // entry valid bit and token stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    // entry value
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign tok_out = tok_reg;

endmodule

// ----- design/mst_ctrl.sv -----
module mst_ctrl #(
    parameter int CAPACITY = mst_pkg::CAPACITY_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mst_pkg::REQ_W-1:0]   req_type,
    input  logic signed [mst_pkg::VAL_W-1:0] item_value,
    input  mst_pkg::tok_t               tail,
    output mst_pkg::tok_t               launch,
    output logic                        busy,
    output logic                        done,
    output logic [mst_pkg::STAT_W-1:0]  status,
    output logic [mst_pkg::MCNT_W-1:0]  member_count
);
    import mst_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [REQ_W-1:0]  op_reg;
    logic [REQ_W-1:0]  op_next;
    logic [VAL_W-1:0]  value_reg;
    logic [VAL_W-1:0]  value_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    tok_t              launch_reg;
    tok_t              launch_next;
    logic              done_reg;
    logic              done_next;
    status_t           status_reg;
    status_t           status_next;
    logic [MCNT_W-1:0] mcount_reg;
    logic [MCNT_W-1:0] mcount_next;
    logic              need_insert;

    // add of an absent value with room left goes on to the insert pass
    assign need_insert = (op_reg == OP_ADD) && !tail.flag && (count_reg != CNT_FULL);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    phase_next = PH_SEARCH;
                end
            end
            PH_SEARCH:
            begin
                if (tail.act)
                begin
                    phase_next = need_insert ? PH_INSERT : PH_IDLE;
                end
            end
            PH_INSERT:
            begin
                if (tail.act)
                begin
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // token launch, count update and result
    always_comb
    begin
        op_next          = op_reg;
        value_next       = value_reg;
        count_next       = count_reg;
        launch_next      = launch_reg;
        launch_next.act  = 1'b0;
        done_next        = 1'b0;
        status_next      = status_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    op_next           = req_type;
                    value_next        = $unsigned(item_value);
                    launch_next.act   = 1'b1;
                    launch_next.kind  = (req_type == OP_REMOVE) ? TK_DELETE : TK_SEARCH;
                    launch_next.value = $unsigned(item_value);
                    launch_next.flag  = 1'b0;
                end
            end
            PH_SEARCH:
            begin
                if (tail.act)
                begin
                    if (op_reg == OP_REMOVE)
                    begin
                        done_next = 1'b1;
                        if (count_reg == '0)
                        begin
                            status_next = STAT_EMPTY;
                        end
                        else if (tail.flag)
                        begin
                            status_next = STAT_REMOVED;
                            count_next  = count_reg - CNT_W'(1);
                        end
                        else
                        begin
                            status_next = STAT_NOT_FOUND;
                        end
                    end
                    else if (op_reg == OP_ADD)
                    begin
                        if (tail.flag)
                        begin
                            done_next   = 1'b1;
                            status_next = STAT_FOUND;
                        end
                        else if (!need_insert)
                        begin
                            done_next   = 1'b1;
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            launch_next.act   = 1'b1;
                            launch_next.kind  = TK_INSERT;
                            launch_next.value = value_reg;
                            launch_next.flag  = 1'b0;
                        end
                    end
                    else
                    begin
                        // find, and the unused code treated as find
                        done_next   = 1'b1;
                        status_next = tail.flag ? STAT_FOUND : STAT_NOT_FOUND;
                    end
                end
            end
            PH_INSERT:
            begin
                if (tail.act)
                begin
                    done_next   = 1'b1;
                    status_next = STAT_ADDED;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
        mcount_next = done_next ? MCNT_W'(count_next) : mcount_reg;
    end

    // control registers and launch token
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            count_reg  <= '0;
            launch_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            launch_reg <= launch_next;
            done_reg   <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg           <= op_next;
        value_reg        <= value_next;
        status_reg       <= status_next;
        mcount_reg       <= mcount_next;
    end

    assign launch       = launch_reg;
    assign busy         = (phase_reg != PH_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign member_count = mcount_reg;

endmodule

// ----- design/mst_checker.sv -----
module mst_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             start,
    input logic                             busy,
    input logic                             done,
    input logic [mst_pkg::STAT_W-1:0]       status,
    input logic [mst_pkg::MCNT_W-1:0]       member_count
);
    import mst_pkg::*;

    // an accepted transaction makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    // a result is only shown once the block is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // one strobe per transaction
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    // status carries a defined code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status <= STAT_EMPTY))
        else $error("undefined status code");

    // empty status only comes with an empty set
    a_count_status: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == STAT_EMPTY) |-> (member_count == '0))
        else $error("empty status with nonzero count");

endmodule

bind membership_set_table mst_checker u_chk (.*);
